[rtl/rgb_conv3x3_filter_macros.svh]
// Assertion macros used by the filter's top-level RTL.
`ifndef RGB_CONV3X3_FILTER_MACROS_SVH
`define RGB_CONV3X3_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rcf_pkg.sv]
`default_nettype none
package rcf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int DIM_W          = 14;
    localparam int CNT_W          = 10;
    localparam int PIX_W          = 24;
    localparam int ACC_W          = 20;
    localparam int DIVD_W         = 19;
    localparam int DVSR_W         = 10;
    localparam int TAPS           = 9;
    localparam int ADDR_W         = 5;

    localparam logic [2:0] REG_KTOP   = 3'd0;
    localparam logic [2:0] REG_KMID   = 3'd1;
    localparam logic [2:0] REG_KBOT   = 3'd2;
    localparam logic [2:0] REG_DIV    = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_MAC,
        S_DIVLD,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [23:0] k_top;
        logic [23:0] k_mid;
        logic [23:0] k_bot;
        logic [9:0]  div;
        logic [10:0] width;
        logic [10:0] height;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic update;
        logic mac_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic tap_last;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[rtl/rcf_stream_if.sv]
`default_nettype none
interface rcf_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface rcf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [9:0] pixel_row;
    logic [9:0] pixel_col;
    logic       frame_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output pixel_row, output pixel_col, output frame_last, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input pixel_row, input pixel_col, input frame_last, output ready);
endinterface
`default_nettype wire

[rtl/rgb_conv3x3_filter.sv]
// Streaming 3x3 RGB convolution filter. Pixels enter in raster order, one item at a time:
// an item that yields no result (a border pixel) only reads and updates the line store; an
// interior pixel also runs nine kernel taps through one multiplier per plane, then a
// 19-step shift-subtract divider, plus any wait for the result register. The next item
// is taken while a result still waits downstream. The user must write the kernel, divisor
// and image size over the APB port only while the filter is idle; the block does not check.
`default_nettype none
`include "rgb_conv3x3_filter_macros.svh"
module rgb_conv3x3_filter #(
    parameter int MAX_WIDTH  = rcf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rcf_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [rcf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    rcf_pix_if.sink                         i_pix,
    rcf_res_if.source                       o_res
);

    rcf_pkg::t_cfg r_cfg;
    rcf_pkg::t_cmd cmd;
    rcf_pkg::t_sts sts;
    logic [2:0]    reg_idx;
    logic          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k_top  <= 24'd0;
            r_cfg.k_mid  <= 24'd256;
            r_cfg.k_bot  <= 24'd0;
            r_cfg.div    <= 10'd1;
            r_cfg.width  <= 11'd1024;
            r_cfg.height <= 11'd1024;
        end else if (wr_en) begin
            case (reg_idx)
                rcf_pkg::REG_KTOP:   r_cfg.k_top  <= pwdata[23:0];
                rcf_pkg::REG_KMID:   r_cfg.k_mid  <= pwdata[23:0];
                rcf_pkg::REG_KBOT:   r_cfg.k_bot  <= pwdata[23:0];
                rcf_pkg::REG_DIV:    r_cfg.div    <= pwdata[9:0];
                rcf_pkg::REG_WIDTH:  r_cfg.width  <= pwdata[10:0];
                rcf_pkg::REG_HEIGHT: r_cfg.height <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rcf_pkg::REG_KTOP:   prdata = 32'(r_cfg.k_top);
            rcf_pkg::REG_KMID:   prdata = 32'(r_cfg.k_mid);
            rcf_pkg::REG_KBOT:   prdata = 32'(r_cfg.k_bot);
            rcf_pkg::REG_DIV:    prdata = 32'(r_cfg.div);
            rcf_pkg::REG_WIDTH:  prdata = 32'(r_cfg.width);
            rcf_pkg::REG_HEIGHT: prdata = 32'(r_cfg.height);
            default:             prdata = '0;
        endcase
    end

    rcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rcf_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_pix   (i_pix),
        .o_res   (o_res)
    );

    `RCF_ASSERT_NEXT(a_one_item, i_pix.valid && i_pix.ready, !i_pix.ready, "Item taken while busy.")
    `RCF_ASSERT_SAME(a_interior, o_res.valid, (o_res.pixel_row != 10'd0) && (o_res.pixel_col != 10'd0), "Border pixel emitted.")
    `RCF_ASSERT_SAME(a_load_free, cmd.out_load, !o_res.valid || o_res.ready, "Result overwritten.")

endmodule
`default_nettype wire

[rtl/rcf_ram.sv]
`default_nettype none
module rcf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/rcf_ctrl.sv]
`default_nettype none
module rcf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire rcf_pkg::t_sts i_sts,
    output rcf_pkg::t_cmd      o_cmd
);

    rcf_pkg::t_state r_state;
    rcf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rcf_pkg::S_IDLE: begin
                if (i_in_valid) n_state = rcf_pkg::S_UPDATE;
            end
            rcf_pkg::S_UPDATE: begin
                n_state = i_sts.emit ? rcf_pkg::S_MAC : rcf_pkg::S_IDLE;
            end
            rcf_pkg::S_MAC: begin
                if (i_sts.tap_last) n_state = rcf_pkg::S_DIVLD;
            end
            rcf_pkg::S_DIVLD: begin
                n_state = rcf_pkg::S_DIV;
            end
            rcf_pkg::S_DIV: begin
                if (i_sts.div_last) n_state = rcf_pkg::S_OUT;
            end
            rcf_pkg::S_OUT: begin
                if (i_sts.out_free) n_state = rcf_pkg::S_IDLE;
            end
            default: n_state = rcf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            rcf_pkg::S_IDLE:   o_cmd.accept   = 1'b1;
            rcf_pkg::S_UPDATE: o_cmd.update   = 1'b1;
            rcf_pkg::S_MAC:    o_cmd.mac_step = 1'b1;
            rcf_pkg::S_DIVLD:  o_cmd.div_load = 1'b1;
            rcf_pkg::S_DIV:    o_cmd.div_step = 1'b1;
            rcf_pkg::S_OUT:    o_cmd.out_load = i_sts.out_free;
            default:           o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/rcf_datapath.sv]
`default_nettype none
module rcf_datapath #(
    parameter int MAX_WIDTH  = rcf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rcf_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rcf_pkg::t_cfg i_cfg,
    input  wire rcf_pkg::t_cmd i_cmd,
    output rcf_pkg::t_sts      o_sts,
    rcf_pix_if.sink            i_pix,
    rcf_res_if.source          o_res
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [rcf_pkg::DIM_W-1:0] MAXW = rcf_pkg::DIM_W'(MAX_WIDTH);
    localparam logic [rcf_pkg::DIM_W-1:0] MAXH = rcf_pkg::DIM_W'(MAX_HEIGHT);
    localparam logic [rcf_pkg::DIM_W-1:0] MIND = rcf_pkg::DIM_W'(3);

    logic [rcf_pkg::CNT_W-1:0] r_row, r_col;
    logic [rcf_pkg::PIX_W-1:0] r_pix;
    logic                      r_inr;
    logic [rcf_pkg::PIX_W-1:0] r_win [rcf_pkg::TAPS];
    logic [1:0]                r_ti, r_tj;
    logic signed [rcf_pkg::ACC_W-1:0] r_acc [3];
    logic [rcf_pkg::DIVD_W-1:0] r_quo [3];
    logic [rcf_pkg::DVSR_W-1:0] r_rem [3];
    logic [2:0]                r_neg;
    logic [4:0]                r_bit;
    logic [rcf_pkg::CNT_W-1:0] r_crow, r_ccol;
    logic                      r_clast;
    logic [rcf_pkg::CNT_W-1:0] r_orow, r_ocol;
    logic                      r_olast;
    logic                      r_out_valid;
    logic [7:0]                r_out [3];

    logic [rcf_pkg::DIM_W-1:0] w_ext, h_ext, w_use, h_use, w_m1, h_m1, c_ext, r_ext;
    logic [rcf_pkg::PIX_W-1:0] top_rd, mid_rd, top_px, mid_px;
    logic                      emit, col_end, in_rng;
    logic [AW-1:0]             addr;
    logic [rcf_pkg::DVSR_W-1:0] dvsr;
    logic [23:0]               krow;
    logic signed [7:0]         coef;
    logic [3:0]                tap;

    assign w_ext = rcf_pkg::DIM_W'(i_cfg.width);
    assign h_ext = rcf_pkg::DIM_W'(i_cfg.height);
    assign w_use = (w_ext < MIND) ? MIND : ((w_ext > MAXW) ? MAXW : w_ext);
    assign h_use = (h_ext < MIND) ? MIND : ((h_ext > MAXH) ? MAXH : h_ext);
    assign w_m1  = w_use - rcf_pkg::DIM_W'(1);
    assign h_m1  = h_use - rcf_pkg::DIM_W'(1);
    assign c_ext = rcf_pkg::DIM_W'(r_col);
    assign r_ext = rcf_pkg::DIM_W'(r_row);
    assign in_rng = c_ext < MAXW;
    assign addr  = AW'(r_col);
    assign dvsr  = (i_cfg.div == '0) ? rcf_pkg::DVSR_W'(1) : i_cfg.div;

    assign emit    = (r_row >= rcf_pkg::CNT_W'(2)) && (r_col >= rcf_pkg::CNT_W'(2))
                     && (r_ext <= h_m1) && (c_ext <= w_m1);
    assign col_end = c_ext >= w_m1;

    rcf_ram #(.WIDTH(rcf_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update && r_inr),
        .i_waddr (addr),
        .i_wdata (mid_rd),
        .i_re    (i_cmd.accept),
        .i_raddr (addr),
        .o_rdata (top_rd)
    );

    rcf_ram #(.WIDTH(rcf_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update && r_inr),
        .i_waddr (addr),
        .i_wdata (r_pix),
        .i_re    (i_cmd.accept),
        .i_raddr (addr),
        .o_rdata (mid_rd)
    );

    assign top_px = r_inr ? top_rd : '0;
    assign mid_px = r_inr ? mid_rd : '0;

    always_comb begin
        case (r_ti)
            2'd0:    krow = i_cfg.k_top;
            2'd1:    krow = i_cfg.k_mid;
            default: krow = i_cfg.k_bot;
        endcase
        coef = $signed(krow[8*r_tj +: 8]);
        tap  = 4'(r_ti) * 4'd3 + 4'(r_tj);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_pix.valid) begin
            r_pix <= {i_pix.blue_in, i_pix.green_in, i_pix.red_in};
            r_inr <= in_rng;
        end
        if (i_cmd.update) begin
            r_crow  <= r_row - rcf_pkg::CNT_W'(1);
            r_ccol  <= r_col - rcf_pkg::CNT_W'(1);
            r_clast <= (r_ext == h_m1) && (c_ext == w_m1);
        end
        if (i_cmd.out_load) begin
            r_orow  <= r_crow;
            r_ocol  <= r_ccol;
            r_olast <= r_clast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            for (int k = 0; k < rcf_pkg::TAPS; k++) r_win[k] <= '0;
        end else if (i_cmd.update) begin
            for (int i = 0; i < 3; i++) begin
                r_win[3*i]   <= r_win[3*i+1];
                r_win[3*i+1] <= r_win[3*i+2];
            end
            r_win[2] <= top_px;
            r_win[5] <= mid_px;
            r_win[8] <= r_pix;
            if (col_end) begin
                r_col <= '0;
                r_row <= (r_ext >= h_m1) ? '0 : r_row + rcf_pkg::CNT_W'(1);
            end else begin
                r_col <= r_col + rcf_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ti <= '0;
            r_tj <= '0;
            for (int p = 0; p < 3; p++) r_acc[p] <= '0;
        end else if (i_cmd.mac_step) begin
            if (r_tj == 2'd2) begin
                r_tj <= '0;
                r_ti <= r_ti + 2'd1;
            end else begin
                r_tj <= r_tj + 2'd1;
            end
            for (int p = 0; p < 3; p++) begin
                r_acc[p] <= r_acc[p]
                    + rcf_pkg::ACC_W'($signed({1'b0, r_win[tap][8*p +: 8]}) * coef);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [rcf_pkg::DVSR_W:0] t;
        if (i_cmd.div_load) begin
            r_bit <= '0;
            for (int p = 0; p < 3; p++) begin
                r_quo[p] <= r_acc[p][rcf_pkg::DIVD_W-1:0];
                r_rem[p] <= '0;
                r_neg[p] <= r_acc[p][rcf_pkg::ACC_W-1];
            end
        end else if (i_cmd.div_step) begin
            r_bit <= r_bit + 5'd1;
            for (int p = 0; p < 3; p++) begin
                t = {r_rem[p], r_quo[p][rcf_pkg::DIVD_W-1]};
                if (t >= {1'b0, dvsr}) begin
                    r_rem[p] <= rcf_pkg::DVSR_W'(t - {1'b0, dvsr});
                    r_quo[p] <= {r_quo[p][rcf_pkg::DIVD_W-2:0], 1'b1};
                end else begin
                    r_rem[p] <= t[rcf_pkg::DVSR_W-1:0];
                    r_quo[p] <= {r_quo[p][rcf_pkg::DIVD_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int p = 0; p < 3; p++) begin
                if (r_neg[p]) r_out[p] <= '0;
                else if (r_quo[p] > rcf_pkg::DIVD_W'(255)) r_out[p] <= 8'd255;
                else r_out[p] <= r_quo[p][7:0];
            end
        end
    end

    assign o_sts.emit     = emit;
    assign o_sts.tap_last = (r_ti == 2'd2) && (r_tj == 2'd2);
    assign o_sts.div_last = r_bit == 5'(rcf_pkg::DIVD_W - 1);
    assign o_sts.out_free = !r_out_valid || o_res.ready;

    assign i_pix.ready      = i_cmd.accept;
    assign o_res.valid      = r_out_valid;
    assign o_res.red_out    = r_out[0];
    assign o_res.green_out  = r_out[1];
    assign o_res.blue_out   = r_out[2];
    assign o_res.pixel_row  = r_orow;
    assign o_res.pixel_col  = r_ocol;
    assign o_res.frame_last = r_olast;

endmodule
`default_nettype wire
